// ===== sv/cthi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cthi_pkg
// Shared widths, channel numbering, clamp limits and register indexes for the
// two-point calibrated temperature / humidity converter.
// ----------------------------------------------------------------------------
package cthi_pkg;

    // raw converter words and differences of two of them
    localparam int RAW_W      = 16;
    localparam int DIFF_W     = RAW_W + 1;

    // calibration points: temperature in 1/8 degC, humidity in 1/2 percent
    localparam int TEMP_Y_W   = 10;
    localparam int HUM_Y_W    = 8;
    localparam int TEMP_YBITS = 3;
    localparam int HUM_YBITS  = 1;
    localparam int Y_W        = TEMP_Y_W;
    localparam int DY_W       = Y_W + 1;

    // products and the interpolation numerator before scaling
    localparam int PROD_W     = DY_W + DIFF_W;
    localparam int SUM_W      = PROD_W + 1;

    // integer part magnitudes below 2^INT_W are resolved exactly
    localparam int INT_W      = 7;

    localparam int NUM_CH     = 2;
    localparam int CH_TEMP    = 0;
    localparam int CH_HUM     = 1;

    localparam int TEMP_HI    = 120;
    localparam int TEMP_LO    = 40;   // magnitude of the lower limit
    localparam int HUM_HI     = 100;
    localparam int HUM_ALIAS  = 72;   // negative integer part that reads as full scale

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_RAW0   = 3'd0,
        REG_TEMP_RAW1   = 3'd1,
        REG_TEMP_EIGHT0 = 3'd2,
        REG_TEMP_EIGHT1 = 3'd3,
        REG_HUM_RAW0    = 3'd4,
        REG_HUM_RAW1    = 3'd5,
        REG_HUM_HALF0   = 3'd6,
        REG_HUM_HALF1   = 3'd7
    } t_cfg_reg;

endpackage

// ===== sv/cthi_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cthi_in_if
// Sample channel: one raw humidity word and one raw temperature word per beat.
// ----------------------------------------------------------------------------
interface cthi_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [cthi_pkg::RAW_W-1:0]  hum_sample;
    logic signed [cthi_pkg::RAW_W-1:0]  temp_sample;

    modport source (output valid, output hum_sample, output temp_sample, input ready);
    modport sink   (input valid, input hum_sample, input temp_sample, output ready);
endinterface

// ===== sv/cthi_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cthi_out_if
// Result channel: calibrated temperature, humidity and fault flags per beat.
// ----------------------------------------------------------------------------
interface cthi_out_if #(
    parameter int FRAC_BITS = 6
);
    logic                         valid;
    logic                         ready;
    logic signed [FRAC_BITS+7:0]  temp_value;
    logic        [FRAC_BITS+6:0]  hum_value;
    logic        [1:0]            calib_fault;

    modport source (output valid, output temp_value, output hum_value,
                    output calib_fault, input ready);
    modport sink   (input valid, input temp_value, input hum_value,
                    input calib_fault, output ready);
endinterface

// ===== sv/calibrated_temp_humidity_interp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibrated_temp_humidity_interp_top
// Two-point linear calibration of a temperature and a humidity sample stream.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock while the result side is not stalled and
// returns one result beat per sample, in order. Most of the pipeline is the
// restoring divider, which resolves one quotient bit per pipeline stage over
// FRAC_BITS + 7 stages; four stages in front form the differences, the two
// products, the scaled numerator and the magnitudes, one more stage splits off
// the upper numerator bits and flags a quotient too wide to keep, and the last
// stage clamps into the output register. Each stage holds its beat only while
// the stage after it is full and stalled, so empty slots fill up while a result
// waits to be taken. Calibration registers are written through the plain write
// port, and the user must do so only while no sample is in flight, which the
// block does not enforce. Equal raw points give a zero result and a fault flag.
// ----------------------------------------------------------------------------
module calibrated_temp_humidity_interp_top #(
    parameter int FRAC_BITS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [cthi_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [cthi_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    cthi_in_if.sink                           i_in,
    cthi_out_if.source                        o_out
);
    import cthi_pkg::*;

    localparam int Q_W        = FRAC_BITS + INT_W;
    localparam int NUM_W      = SUM_W + FRAC_BITS - HUM_YBITS;
    localparam int HI_W       = NUM_W - Q_W;
    localparam int TEMP_W     = FRAC_BITS + 8;
    localparam int HUM_W      = FRAC_BITS + 7;
    localparam int TEMP_SHIFT = FRAC_BITS - TEMP_YBITS;
    localparam int HUM_SHIFT  = FRAC_BITS - HUM_YBITS;
    localparam int DIV_FIRST  = 4;
    localparam int NS         = DIV_FIRST + Q_W + 2;

    localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(TEMP_HI << FRAC_BITS);
    localparam logic [TEMP_W-1:0] TEMP_MIN = TEMP_W'(-(TEMP_LO << FRAC_BITS));
    localparam logic [HUM_W-1:0]  HUM_MAX  = HUM_W'(HUM_HI << FRAC_BITS);

    typedef struct packed {
        logic [RAW_W-1:0] rem;
        logic [RAW_W-1:0] dmag;
        logic [Q_W-1:0]   nlow;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             ovf;
        logic             flt;
    } t_div;

    // one restoring step: bring down the next numerator bit, subtract if it fits
    function automatic t_div f_div_step(input t_div a);
        t_div         r;
        logic [RAW_W:0] part;
        logic [RAW_W:0] diff;
        r    = a;
        part = {a.rem, a.nlow[Q_W-1]};
        diff = part - {1'b0, a.dmag};
        r.nlow = {a.nlow[Q_W-2:0], 1'b0};
        if (part >= {1'b0, a.dmag}) begin
            r.rem = diff[RAW_W-1:0];
            r.quo = {a.quo[Q_W-2:0], 1'b1};
        end else begin
            r.rem = part[RAW_W-1:0];
            r.quo = {a.quo[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------------
    logic signed [RAW_W-1:0]    r_temp_raw0, r_temp_raw1, r_hum_raw0, r_hum_raw1;
    logic        [TEMP_Y_W-1:0] r_temp_eighth0, r_temp_eighth1;
    logic        [HUM_Y_W-1:0]  r_hum_half0, r_hum_half1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_raw0    <= '0;
            r_temp_raw1    <= RAW_W'(1);
            r_temp_eighth0 <= '0;
            r_temp_eighth1 <= '0;
            r_hum_raw0     <= '0;
            r_hum_raw1     <= RAW_W'(1);
            r_hum_half0    <= '0;
            r_hum_half1    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_TEMP_RAW0:   r_temp_raw0    <= i_cfg_wdata[RAW_W-1:0];
                REG_TEMP_RAW1:   r_temp_raw1    <= i_cfg_wdata[RAW_W-1:0];
                REG_TEMP_EIGHT0: r_temp_eighth0 <= i_cfg_wdata[TEMP_Y_W-1:0];
                REG_TEMP_EIGHT1: r_temp_eighth1 <= i_cfg_wdata[TEMP_Y_W-1:0];
                REG_HUM_RAW0:    r_hum_raw0     <= i_cfg_wdata[RAW_W-1:0];
                REG_HUM_RAW1:    r_hum_raw1     <= i_cfg_wdata[RAW_W-1:0];
                REG_HUM_HALF0:   r_hum_half0    <= i_cfg_wdata[HUM_Y_W-1:0];
                REG_HUM_HALF1:   r_hum_half1    <= i_cfg_wdata[HUM_Y_W-1:0];
                default:         r_hum_half1    <= r_hum_half1;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage advance: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready  = en[0];
    assign o_out.valid = r_vld[NS-1];

    // ------------------------------------------------------------------------
    // datapath, both channels side by side
    // ------------------------------------------------------------------------
    logic signed [RAW_W-1:0] x  [NUM_CH];
    logic signed [RAW_W-1:0] x0 [NUM_CH];
    logic signed [RAW_W-1:0] x1 [NUM_CH];
    logic        [Y_W-1:0]   y0 [NUM_CH];
    logic        [Y_W-1:0]   y1 [NUM_CH];

    assign x[CH_TEMP]  = i_in.temp_sample;
    assign x[CH_HUM]   = i_in.hum_sample;
    assign x0[CH_TEMP] = r_temp_raw0;
    assign x1[CH_TEMP] = r_temp_raw1;
    assign x0[CH_HUM]  = r_hum_raw0;
    assign x1[CH_HUM]  = r_hum_raw1;
    assign y0[CH_TEMP] = r_temp_eighth0;
    assign y1[CH_TEMP] = r_temp_eighth1;
    assign y0[CH_HUM]  = Y_W'(r_hum_half0);
    assign y1[CH_HUM]  = Y_W'(r_hum_half1);

    logic signed [DIFF_W-1:0] r_s1_dx [NUM_CH], n_s1_dx [NUM_CH];
    logic signed [DIFF_W-1:0] r_s1_d  [NUM_CH], n_s1_d  [NUM_CH];
    logic signed [DY_W-1:0]   r_s1_dy [NUM_CH], n_s1_dy [NUM_CH];
    logic        [Y_W-1:0]    r_s1_y0 [NUM_CH];
    logic                     r_s1_flt[NUM_CH], n_s1_flt[NUM_CH];

    logic signed [PROD_W-1:0] r_s2_p0 [NUM_CH], n_s2_p0 [NUM_CH];
    logic signed [PROD_W-1:0] r_s2_p1 [NUM_CH], n_s2_p1 [NUM_CH];
    logic signed [DIFF_W-1:0] r_s2_d  [NUM_CH];
    logic                     r_s2_flt[NUM_CH];

    logic signed [NUM_W-1:0]  r_s3_n  [NUM_CH], n_s3_n  [NUM_CH];
    logic signed [DIFF_W-1:0] r_s3_d  [NUM_CH];
    logic                     r_s3_flt[NUM_CH];

    logic        [NUM_W-1:0]  r_s4_nmag[NUM_CH], n_s4_nmag[NUM_CH];
    logic        [RAW_W-1:0]  r_s4_dmag[NUM_CH], n_s4_dmag[NUM_CH];
    logic                     r_s4_neg [NUM_CH], n_s4_neg [NUM_CH];
    logic                     r_s4_flt [NUM_CH];

    t_div                     r_div [Q_W+1][NUM_CH];
    t_div                     n_div0[NUM_CH];

    logic [TEMP_W-1:0]        r_temp, n_temp;
    logic [HUM_W-1:0]         r_hum, n_hum;
    logic [1:0]               r_flt, n_flt;

    always_comb begin
        logic signed [SUM_W-1:0]  sum;
        logic        [DIFF_W-1:0] dabs;
        logic        [HI_W-1:0]   hi;
        for (int c = 0; c < NUM_CH; c++) begin
            // differences
            n_s1_dx[c]  = DIFF_W'(x[c]) - DIFF_W'(x0[c]);
            n_s1_d[c]   = DIFF_W'(x1[c]) - DIFF_W'(x0[c]);
            n_s1_dy[c]  = $signed({1'b0, y1[c]}) - $signed({1'b0, y0[c]});
            n_s1_flt[c] = (x0[c] == x1[c]);

            // y0 * d + (y1 - y0) * (x - x0)
            n_s2_p0[c] = PROD_W'($signed({1'b0, r_s1_y0[c]})) * PROD_W'(r_s1_d[c]);
            n_s2_p1[c] = PROD_W'(r_s1_dy[c]) * PROD_W'(r_s1_dx[c]);

            // numerator scaled to the output fraction
            sum = SUM_W'(r_s2_p0[c]) + SUM_W'(r_s2_p1[c]);
            if (c == CH_TEMP) begin
                n_s3_n[c] = NUM_W'(sum) <<< TEMP_SHIFT;
            end else begin
                n_s3_n[c] = NUM_W'(sum) <<< HUM_SHIFT;
            end

            // sign and magnitude, quotient rounds toward zero
            n_s4_nmag[c] = r_s3_n[c][NUM_W-1] ? NUM_W'(NUM_W'(0) - r_s3_n[c])
                                              : NUM_W'(r_s3_n[c]);
            dabs         = r_s3_d[c][DIFF_W-1] ? DIFF_W'(DIFF_W'(0) - r_s3_d[c])
                                               : DIFF_W'(r_s3_d[c]);
            n_s4_dmag[c] = dabs[RAW_W-1:0];
            n_s4_neg[c]  = r_s3_n[c][NUM_W-1] ^ r_s3_d[c][DIFF_W-1];

            // quotient too wide for the kept bits means the clamp decides
            hi               = r_s4_nmag[c][NUM_W-1:Q_W];
            n_div0[c].rem    = hi[RAW_W-1:0];
            n_div0[c].dmag   = r_s4_dmag[c];
            n_div0[c].nlow   = r_s4_nmag[c][Q_W-1:0];
            n_div0[c].quo    = '0;
            n_div0[c].neg    = r_s4_neg[c];
            n_div0[c].ovf    = (hi >= HI_W'(r_s4_dmag[c]));
            n_div0[c].flt    = r_s4_flt[c];
        end
    end

    // clamp on the integer part of the quotient
    always_comb begin
        t_div             tq;
        t_div             hq;
        logic [INT_W-1:0] tip;
        logic [INT_W-1:0] hip;
        tq  = r_div[Q_W][CH_TEMP];
        hq  = r_div[Q_W][CH_HUM];
        tip = tq.quo[Q_W-1:FRAC_BITS];
        hip = hq.quo[Q_W-1:FRAC_BITS];

        if (tq.flt) begin
            n_temp = '0;
        end else if (!tq.neg) begin
            n_temp = (tq.ovf || tip >= INT_W'(TEMP_HI)) ? TEMP_MAX : TEMP_W'(tq.quo);
        end else begin
            n_temp = (tq.ovf || tip > INT_W'(TEMP_LO)) ? TEMP_MIN
                                                       : TEMP_W'(TEMP_W'(0) - TEMP_W'(tq.quo));
        end

        priority if (hq.flt) begin
            n_hum = '0;
        end else if (!hq.neg) begin
            n_hum = (hq.ovf || hip >= INT_W'(HUM_HI)) ? HUM_MAX : HUM_W'(hq.quo);
        end else if (!hq.ovf && hip == INT_W'(HUM_ALIAS)) begin
            n_hum = HUM_MAX;
        end else if (hq.ovf || hip != '0) begin
            n_hum = '0;
        end else begin
            // just below zero passes as its two's complement pattern
            n_hum = HUM_W'(HUM_W'(0) - HUM_W'(hq.quo));
        end

        n_flt = {hq.flt, tq.flt};
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (en[0]) begin
                r_s1_dx[c]  <= n_s1_dx[c];
                r_s1_d[c]   <= n_s1_d[c];
                r_s1_dy[c]  <= n_s1_dy[c];
                r_s1_y0[c]  <= y0[c];
                r_s1_flt[c] <= n_s1_flt[c];
            end
            if (en[1]) begin
                r_s2_p0[c]  <= n_s2_p0[c];
                r_s2_p1[c]  <= n_s2_p1[c];
                r_s2_d[c]   <= r_s1_d[c];
                r_s2_flt[c] <= r_s1_flt[c];
            end
            if (en[2]) begin
                r_s3_n[c]   <= n_s3_n[c];
                r_s3_d[c]   <= r_s2_d[c];
                r_s3_flt[c] <= r_s2_flt[c];
            end
            if (en[3]) begin
                r_s4_nmag[c] <= n_s4_nmag[c];
                r_s4_dmag[c] <= n_s4_dmag[c];
                r_s4_neg[c]  <= n_s4_neg[c];
                r_s4_flt[c]  <= r_s3_flt[c];
            end
            if (en[DIV_FIRST]) begin
                r_div[0][c] <= n_div0[c];
            end
            for (int j = 0; j < Q_W; j++) begin
                if (en[DIV_FIRST+1+j]) begin
                    r_div[j+1][c] <= f_div_step(r_div[j][c]);
                end
            end
        end
        if (en[NS-1]) begin
            r_temp <= n_temp;
            r_hum  <= n_hum;
            r_flt  <= n_flt;
        end
    end

    assign o_out.temp_value  = r_temp;
    assign o_out.hum_value   = r_hum;
    assign o_out.calib_fault = r_flt;

endmodule
